[rtl/frsp_pkg.sv]
package frsp_pkg;

   // fixed geometry
   localparam int LOCAL_TYPES = 16;
   localparam int LT_W        = 4;
   localparam int CSR_AW      = 2;
   localparam int CSR_DW      = 16;

   // register indexes
   localparam logic [CSR_AW-1:0] CSR_LAP_MSG   = 2'd0;
   localparam logic [CSR_AW-1:0] CSR_TIME_FLD  = 2'd1;
   localparam logic [CSR_AW-1:0] CSR_SPEED_FLD = 2'd2;

   // event codes
   localparam logic [2:0] EV_HDR_OK   = 3'd0;
   localparam logic [2:0] EV_HDR_BAD  = 3'd1;
   localparam logic [2:0] EV_TIME     = 3'd2;
   localparam logic [2:0] EV_SPEED    = 3'd3;
   localparam logic [2:0] EV_CRC_OK   = 3'd4;
   localparam logic [2:0] EV_CRC_BAD  = 3'd5;
   localparam logic [2:0] EV_BAD_TYPE = 3'd6;

   // record header types
   localparam logic [3:0] REC_DATA = 4'h0;
   localparam logic [3:0] REC_DEF  = 4'h4;

   typedef struct packed {
      logic       start_file;
      logic [7:0] data_byte;
   } req_item_type;

   typedef struct packed {
      logic [2:0]  event_kind;
      logic [31:0] event_value;
   } rsp_item_type;

   // crc-16 nibble table
   function automatic logic [15:0] crc_nibble(input logic [3:0] n);
      logic [15:0] r;
      case (n)
         4'h0: r = 16'h0000;
         4'h1: r = 16'hCC01;
         4'h2: r = 16'hD801;
         4'h3: r = 16'h1400;
         4'h4: r = 16'hF001;
         4'h5: r = 16'h3C00;
         4'h6: r = 16'h2800;
         4'h7: r = 16'hE401;
         4'h8: r = 16'hA001;
         4'h9: r = 16'h6C00;
         4'hA: r = 16'h7800;
         4'hB: r = 16'hB401;
         4'hC: r = 16'h5000;
         4'hD: r = 16'h9C01;
         4'hE: r = 16'h8801;
         4'hF: r = 16'h4400;
         default: r = 16'h0000;
      endcase
      return r;
   endfunction

   // crc over one byte, low nibble first
   function automatic logic [15:0] crc_byte(input logic [15:0] c, input logic [7:0] b);
      logic [15:0] x;
      x = {4'h0, c[15:4]} ^ crc_nibble(c[3:0]) ^ crc_nibble(b[3:0]);
      x = {4'h0, x[15:4]} ^ crc_nibble(x[3:0]) ^ crc_nibble(b[7:4]);
      return x;
   endfunction

endpackage

[rtl/frsp_fifo.sv]
module frsp_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] wr_data,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] rd_data,
   output logic             empty
);
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   logic [WIDTH-1:0] slot_ff [DEPTH];
   logic [AW-1:0]    wp_ff, wp_in, rp_ff, rp_in;
   logic [AW:0]      cnt_ff, cnt_in;
   logic             do_push, do_pop;

   assign full    = (cnt_ff == (AW+1)'(DEPTH));
   assign empty   = (cnt_ff == '0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign rd_data = slot_ff[rp_ff];

   // pointer and count update
   always_comb begin
      wp_in  = wp_ff;
      rp_in  = rp_ff;
      cnt_in = cnt_ff;
      if (do_push) begin
         wp_in = (wp_ff == AW'(DEPTH-1)) ? '0 : wp_ff + 1'b1;
      end
      if (do_pop) begin
         rp_in = (rp_ff == AW'(DEPTH-1)) ? '0 : rp_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff  <= '0;
         rp_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wp_ff  <= wp_in;
         rp_ff  <= rp_in;
         cnt_ff <= cnt_in;
      end
   end

   // storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wp_ff] <= wr_data;
      end
   end

endmodule

[rtl/frsp_core.sv]
module frsp_core #(
   parameter int MAX_FIELDS = 64
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   input  frsp_pkg::req_item_type in_item,
   output logic                  in_take,
   input  logic                  out_full,
   output logic                  out_push,
   output frsp_pkg::rsp_item_type out_item,
   input  logic [15:0]           lap_msg,
   input  logic [7:0]            time_fld,
   input  logic [7:0]            speed_fld
);
   import frsp_pkg::*;

   localparam int MEM_DEPTH = LOCAL_TYPES * MAX_FIELDS;
   localparam int MEM_AW    = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;

   typedef enum logic [3:0] {
      PH_HEADER, PH_RECORD, PH_DEF_FIXED, PH_DEF_FIELDS, PH_DATA,
      PH_SEEK_RD, PH_SEEK_CHK, PH_FILE_CRC, PH_DONE
   } phase_type;

   typedef enum logic [1:0] {MODE_NONE, MODE_TIME, MODE_SPEED} mode_type;

   phase_type         ph_ff, ph_in, c_ph;
   logic [15:0]       crc_ff, crc_in, c_crc;
   logic [7:0]        bpos_ff, bpos_in, c_bpos;
   logic [31:0]       left_ff, left_in, c_left;
   logic [LT_W-1:0]   lt_ff, lt_in, c_lt;
   logic [7:0]        fidx_ff, fidx_in, c_fidx;
   logic [7:0]        fbi_ff, fbi_in, c_fbi;
   logic [31:0]       acc_ff, acc_in, c_acc;
   logic              first_ff, first_in, c_first;
   mode_type          mode_ff, mode_in, c_mode;
   logic [LOCAL_TYPES-1:0] valid_ff, valid_in, c_valid;
   logic [7:0]        fsize_ff, fsize_in;
   logic [7:0]        fnum_ff, fnum_in;
   logic [7:0]        lo_ff, lo_in;

   // per local type definition heads
   logic [15:0]       glob_ff [LOCAL_TYPES];
   logic [7:0]        cnt_ff  [LOCAL_TYPES];
   logic              glob_lo_we, glob_hi_we, cnt_we;
   logic [7:0]        cnt_wdata;

   // field table memory
   logic [15:0]       fmem [MEM_DEPTH];
   logic [15:0]       rd_data_ff;
   logic              mem_we, mem_rd;
   logic [MEM_AW-1:0] mem_addr;

   logic [7:0]        b;
   logic [3:0]        rtype;
   logic [7:0]        cur_cnt;
   logic [7:0]        fbi_next;
   logic [15:0]       hword;
   logic              seeking;

   assign b       = in_item.data_byte;
   assign rtype   = b[7:4];
   assign seeking = (ph_ff == PH_SEEK_RD) || (ph_ff == PH_SEEK_CHK);
   assign cur_cnt = valid_ff[lt_ff] ? cnt_ff[lt_ff] : 8'd0;
   assign mem_addr = MEM_AW'(32'(lt_ff) * MAX_FIELDS) + MEM_AW'(fidx_ff);

   // parse step: one byte, or one table read or check while seeking
   always_comb begin
      in_take    = 1'b0;
      out_push   = 1'b0;
      out_item   = '0;
      mem_we     = 1'b0;
      mem_rd     = 1'b0;
      glob_lo_we = 1'b0;
      glob_hi_we = 1'b0;
      cnt_we     = 1'b0;
      cnt_wdata  = b;
      fbi_next   = fbi_ff + 1'b1;
      hword      = {b, acc_ff[7:0]};

      c_ph    = ph_ff;
      c_crc   = crc_ff;
      c_bpos  = bpos_ff;
      c_left  = left_ff;
      c_lt    = lt_ff;
      c_fidx  = fidx_ff;
      c_fbi   = fbi_ff;
      c_acc   = acc_ff;
      c_first = first_ff;
      c_mode  = mode_ff;
      c_valid = valid_ff;

      if (!seeking && in_valid && !out_full && in_item.start_file) begin
         c_ph    = PH_HEADER;
         c_crc   = '0;
         c_bpos  = '0;
         c_left  = '0;
         c_lt    = '0;
         c_fidx  = '0;
         c_fbi   = '0;
         c_acc   = '0;
         c_first = 1'b1;
         c_mode  = MODE_NONE;
         c_valid = '0;
      end

      ph_in    = c_ph;
      crc_in   = c_crc;
      bpos_in  = c_bpos;
      left_in  = c_left;
      lt_in    = c_lt;
      fidx_in  = c_fidx;
      fbi_in   = c_fbi;
      acc_in   = c_acc;
      first_in = c_first;
      mode_in  = c_mode;
      valid_in = c_valid;
      fsize_in = fsize_ff;
      fnum_in  = fnum_ff;
      lo_in    = lo_ff;
      hword    = {b, c_acc[7:0]};

      if (seeking) begin
         // walk the field table to the next field with bytes
         if (ph_ff == PH_SEEK_RD) begin
            if (fidx_ff >= cur_cnt) begin
               ph_in   = (left_ff == '0) ? PH_FILE_CRC : PH_RECORD;
               bpos_in = '0;
               acc_in  = '0;
            end else begin
               mem_rd = 1'b1;
               ph_in  = PH_SEEK_CHK;
            end
         end else begin
            if (rd_data_ff[15:8] != 8'd0) begin
               ph_in    = PH_DATA;
               fsize_in = rd_data_ff[15:8];
               fnum_in  = rd_data_ff[7:0];
               fbi_in   = '0;
               acc_in   = '0;
            end else begin
               fidx_in = fidx_ff + 1'b1;
               ph_in   = PH_SEEK_RD;
            end
         end
      end else if (in_valid && !out_full) begin
         in_take = 1'b1;
         // data area bytes feed the crc and the size count
         if (c_ph != PH_HEADER && c_ph != PH_FILE_CRC && c_ph != PH_DONE) begin
            crc_in = crc_byte(c_crc, b);
            if (c_left != '0) begin
               left_in = c_left - 1'b1;
            end
         end
         case (c_ph)
            PH_HEADER: begin
               if (c_bpos < 8'd12) begin
                  crc_in = crc_byte(c_crc, b);
               end
               case (c_bpos)
                  8'd4: left_in[7:0]   = b;
                  8'd5: left_in[15:8]  = b;
                  8'd6: left_in[23:16] = b;
                  8'd7: left_in[31:24] = b;
                  default: ;
               endcase
               if (c_bpos == 8'd12) begin
                  acc_in = {24'd0, b};
               end
               if (c_bpos == 8'd13) begin
                  out_push = 1'b1;
                  if (hword == c_crc) begin
                     out_item.event_kind = EV_HDR_OK;
                     crc_in  = '0;
                     ph_in   = (c_left == '0) ? PH_FILE_CRC : PH_RECORD;
                     bpos_in = '0;
                     acc_in  = '0;
                  end else begin
                     out_item.event_kind = EV_HDR_BAD;
                     ph_in = PH_DONE;
                  end
               end else begin
                  bpos_in = c_bpos + 1'b1;
               end
            end
            PH_RECORD: begin
               lt_in = b[3:0];
               if (rtype == REC_DEF) begin
                  ph_in   = PH_DEF_FIXED;
                  bpos_in = '0;
               end else if (rtype == REC_DATA) begin
                  if (c_first) begin
                     mode_in  = MODE_TIME;
                     first_in = 1'b0;
                  end else if (c_valid[b[3:0]] && glob_ff[b[3:0]] == lap_msg) begin
                     mode_in = MODE_SPEED;
                  end else begin
                     mode_in = MODE_NONE;
                  end
                  fidx_in = '0;
                  ph_in   = PH_SEEK_RD;
               end else begin
                  out_push = 1'b1;
                  out_item.event_kind = EV_BAD_TYPE;
                  ph_in = PH_DONE;
               end
            end
            PH_DEF_FIXED: begin
               bpos_in = c_bpos + 1'b1;
               if (c_bpos == 8'd2) begin
                  glob_lo_we = 1'b1;
               end else if (c_bpos == 8'd3) begin
                  glob_hi_we = 1'b1;
               end else if (c_bpos == 8'd4) begin
                  cnt_we    = 1'b1;
                  cnt_wdata = (b > 8'(MAX_FIELDS)) ? 8'(MAX_FIELDS) : b;
                  valid_in[c_lt] = 1'b1;
                  fidx_in = '0;
                  bpos_in = '0;
                  if (b == 8'd0) begin
                     ph_in  = (left_in == '0) ? PH_FILE_CRC : PH_RECORD;
                     acc_in = '0;
                  end else begin
                     acc_in = {24'd0, b};
                     ph_in  = PH_DEF_FIELDS;
                  end
               end
            end
            PH_DEF_FIELDS: begin
               if (c_bpos == 8'd0) begin
                  lo_in   = b;
                  bpos_in = 8'd1;
               end else if (c_bpos == 8'd1) begin
                  mem_we  = (32'(c_fidx) < MAX_FIELDS);
                  bpos_in = 8'd2;
               end else begin
                  fidx_in = c_fidx + 1'b1;
                  bpos_in = '0;
                  if (fidx_in >= c_acc[7:0]) begin
                     ph_in  = (left_in == '0) ? PH_FILE_CRC : PH_RECORD;
                     acc_in = '0;
                  end
               end
            end
            PH_DATA: begin
               case (c_fbi)
                  8'd0: acc_in[7:0]   = b;
                  8'd1: acc_in[15:8]  = b;
                  8'd2: acc_in[23:16] = b;
                  8'd3: acc_in[31:24] = b;
                  default: ;
               endcase
               fbi_in = fbi_next;
               if (fbi_next >= fsize_ff) begin
                  if (c_mode == MODE_TIME && fnum_ff == time_fld) begin
                     out_push = 1'b1;
                     out_item.event_kind  = EV_TIME;
                     out_item.event_value = acc_in;
                  end else if (c_mode == MODE_SPEED && fnum_ff == speed_fld) begin
                     out_push = 1'b1;
                     out_item.event_kind  = EV_SPEED;
                     out_item.event_value = acc_in;
                  end
                  fidx_in = c_fidx + 1'b1;
                  ph_in   = PH_SEEK_RD;
               end
            end
            PH_FILE_CRC: begin
               if (c_bpos == 8'd0) begin
                  acc_in  = {24'd0, b};
                  bpos_in = 8'd1;
               end else begin
                  out_push = 1'b1;
                  out_item.event_kind = (hword == c_crc) ? EV_CRC_OK : EV_CRC_BAD;
                  ph_in = PH_DONE;
               end
            end
            default: ;
         endcase
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         ph_ff    <= PH_HEADER;
         crc_ff   <= '0;
         bpos_ff  <= '0;
         left_ff  <= '0;
         lt_ff    <= '0;
         fidx_ff  <= '0;
         fbi_ff   <= '0;
         acc_ff   <= '0;
         first_ff <= 1'b1;
         mode_ff  <= MODE_NONE;
         valid_ff <= '0;
      end else begin
         ph_ff    <= ph_in;
         crc_ff   <= crc_in;
         bpos_ff  <= bpos_in;
         left_ff  <= left_in;
         lt_ff    <= lt_in;
         fidx_ff  <= fidx_in;
         fbi_ff   <= fbi_in;
         acc_ff   <= acc_in;
         first_ff <= first_in;
         mode_ff  <= mode_in;
         valid_ff <= valid_in;
      end
   end

   // payload registers and definition heads
   always_ff @(posedge clock) begin
      fsize_ff <= fsize_in;
      fnum_ff  <= fnum_in;
      lo_ff    <= lo_in;
      if (glob_lo_we) begin
         glob_ff[lt_ff] <= {8'd0, b};
      end
      if (glob_hi_we) begin
         glob_ff[lt_ff][15:8] <= b;
      end
      if (cnt_we) begin
         cnt_ff[lt_ff] <= cnt_wdata;
      end
   end

   // field table: one write or one read per cycle
   always_ff @(posedge clock) begin
      if (mem_we) begin
         fmem[mem_addr] <= {b, lo_ff};
      end
      if (mem_rd) begin
         rd_data_ff <= fmem[mem_addr];
      end
   end

endmodule

[rtl/fit_record_stream_parser.sv]
// channel   direction  handshake            payload
// req       in         req_push / req_full   req_data_byte, req_start_file
// rsp       out        rsp_pop / rsp_empty   rsp_event_kind, rsp_event_value
// csr       in         csr_we                csr_addr, csr_wdata
//
// One byte per cycle through the parser, when neither queue side stalls, while
// inside a header, record header, definition or data field. After each data
// field and at each data record header the field table memory is walked to
// the next field with a nonzero size. Reset is synchronous and clears all
// control state; no clearing pass. Either queue side may stall independently.
module fit_record_stream_parser #(
   parameter int MAX_FIELDS = 64
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_push,
   output logic        req_full,
   input  logic [7:0]  req_data_byte,
   input  logic        req_start_file,
   output logic        rsp_empty,
   input  logic        rsp_pop,
   output logic [2:0]  rsp_event_kind,
   output logic [31:0] rsp_event_value,
   input  logic        csr_we,
   input  logic [frsp_pkg::CSR_AW-1:0] csr_addr,
   input  logic [frsp_pkg::CSR_DW-1:0] csr_wdata
);
   import frsp_pkg::*;

   req_item_type req_in, req_head;
   rsp_item_type rsp_new, rsp_head;
   logic         req_empty, req_take;
   logic         rsp_full, rsp_push;
   logic [15:0]  lap_ff;
   logic [7:0]   time_ff, speed_ff;

   assign req_in.data_byte  = req_data_byte;
   assign req_in.start_file = req_start_file;
   assign rsp_event_kind    = rsp_head.event_kind;
   assign rsp_event_value   = rsp_head.event_value;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         lap_ff   <= 16'd19;
         time_ff  <= 8'd4;
         speed_ff <= 8'd13;
      end else if (csr_we) begin
         case (csr_addr)
            CSR_LAP_MSG:   lap_ff   <= csr_wdata;
            CSR_TIME_FLD:  time_ff  <= csr_wdata[7:0];
            CSR_SPEED_FLD: speed_ff <= csr_wdata[7:0];
            default: ;
         endcase
      end
   end

   // front: input item queue
   frsp_fifo #(.WIDTH($bits(req_item_type)), .DEPTH(2)) u_req_q (
      .clock   (clock),
      .reset   (reset),
      .push    (req_push),
      .wr_data (req_in),
      .full    (req_full),
      .pop     (req_take),
      .rd_data (req_head),
      .empty   (req_empty)
   );

   // back: parser
   frsp_core #(.MAX_FIELDS(MAX_FIELDS)) u_core (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (!req_empty),
      .in_item   (req_head),
      .in_take   (req_take),
      .out_full  (rsp_full),
      .out_push  (rsp_push),
      .out_item  (rsp_new),
      .lap_msg   (lap_ff),
      .time_fld  (time_ff),
      .speed_fld (speed_ff)
   );

   // result queue
   frsp_fifo #(.WIDTH($bits(rsp_item_type)), .DEPTH(2)) u_rsp_q (
      .clock   (clock),
      .reset   (reset),
      .push    (rsp_push),
      .wr_data (rsp_new),
      .full    (rsp_full),
      .pop     (rsp_pop),
      .rd_data (rsp_head),
      .empty   (rsp_empty)
   );

endmodule
